// ===== src/fptt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fptt_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int POS_W      = 16;
    localparam int DVD_W      = 16;
    localparam int DVS_W      = 12;

    localparam logic [1:0] FUNC_PRUNE    = 2'd0;
    localparam logic [1:0] FUNC_READ     = 2'd1;
    localparam logic [1:0] FUNC_DISPLACE = 2'd2;
    localparam logic [1:0] FUNC_RESEED   = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_INDEX = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_GAP   = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_GAP    = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_DATA,
        ST_RD_CALC,
        ST_MG_ISSUE,
        ST_MG_CHECK,
        ST_PV_ISSUE,
        ST_PV_LOAD,
        ST_PJ_ISSUE,
        ST_PJ_SQ,
        ST_PJ_CMP,
        ST_RS_DIV_NX,
        ST_RS_DIV_NY,
        ST_RS_DIV_SX,
        ST_RS_DIV_SY,
        ST_RS_POINT,
        ST_RS_ISSUE,
        ST_RS_SQ,
        ST_RS_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [POS_W-1:0] wx;
        logic [POS_W-1:0] wy;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== src/fptt_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fptt_mem (
    input  wire                          i_clk,
    input  wire fptt_pkg::t_mem_req      i_req,
    output logic [fptt_pkg::POS_W-1:0]   o_rx,
    output logic [fptt_pkg::POS_W-1:0]   o_ry
);

    logic [2*fptt_pkg::POS_W-1:0] r_mem [fptt_pkg::MAX_POINTS];
    logic [2*fptt_pkg::POS_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= {i_req.wy, i_req.wx};
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rx = r_rdata[fptt_pkg::POS_W-1:0];
    assign o_ry = r_rdata[2*fptt_pkg::POS_W-1:fptt_pkg::POS_W];

endmodule

`default_nettype wire

// ===== src/fptt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fptt_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [fptt_pkg::DVD_W-1:0]   i_dividend,
    input  wire  [fptt_pkg::DVS_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [fptt_pkg::DVD_W-1:0]   o_quot,
    output logic [fptt_pkg::DVS_W-1:0]   o_rem
);

    localparam int STEP_W = $clog2(fptt_pkg::DVD_W);

    logic                        r_busy;
    logic                        r_done;
    logic [STEP_W-1:0]           r_step;
    logic [fptt_pkg::DVD_W-1:0]  r_quot;
    logic [fptt_pkg::DVS_W-1:0]  r_rem;
    logic [fptt_pkg::DVS_W-1:0]  r_dvs;
    logic [fptt_pkg::DVS_W:0]    n_shift;
    logic                        n_ge;

    always_comb begin
        n_shift = {r_rem, r_quot[fptt_pkg::DVD_W-1]};
        n_ge    = n_shift >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(fptt_pkg::DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[fptt_pkg::DVD_W-2:0], n_ge};
            if (n_ge) begin
                r_rem <= fptt_pkg::DVS_W'(n_shift - {1'b0, r_dvs});
            end else begin
                r_rem <= n_shift[fptt_pkg::DVS_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== src/fptt_near.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fptt_near (
    input  wire                          i_clk,
    input  wire  [fptt_pkg::POS_W-1:0]   i_ax,
    input  wire  [fptt_pkg::POS_W-1:0]   i_ay,
    input  wire  [fptt_pkg::POS_W-1:0]   i_bx,
    input  wire  [fptt_pkg::POS_W-1:0]   i_by,
    input  wire  [23:0]                  i_lim,
    output logic                         o_near
);

    logic signed [16:0] n_dx;
    logic signed [16:0] n_dy;
    logic signed [33:0] n_px;
    logic signed [33:0] n_py;
    logic [31:0]        r_dx2;
    logic [31:0]        r_dy2;

    always_comb begin
        n_dx = $signed({i_ax[15], i_ax}) - $signed({i_bx[15], i_bx});
        n_dy = $signed({i_ay[15], i_ay}) - $signed({i_by[15], i_by});
        n_px = n_dx * n_dx;
        n_py = n_dy * n_dy;
    end

    always_ff @(posedge i_clk) begin
        r_dx2 <= n_px[31:0];
        r_dy2 <= n_py[31:0];
    end

    assign o_near = ({1'b0, r_dx2} + {1'b0, r_dy2}) < {9'b0, i_lim};

endmodule

`default_nettype wire

// ===== src/flow_point_tracker_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel     Dir  Signals                 Contents
// s_axis      in   tvalid tready tdata[48] func, entry_index, flow_dx, flow_dy
// m_axis      out  tvalid tready tdata[72] status, point_count, point_x, point_y,
//                                          lookup_x, lookup_y
// cfg         in   i_cfg_we i_cfg_index    0 image_width, 1 image_height, 2 grid_gap
//
// Read and displace issue the memory read when taken, then pass RD_DATA, RD_CALC and DONE.
// Prune runs a margin pass over every point (issue, check), then loads each kept point as
// pivot and compares it with each later point (issue, square, compare), keeping far ones.
// Reseed takes 4 divisions, then for each grid point scans the listed points (issue,
// square, compare) and appends the grid point if none lies near.
// Synchronous active-low reset empties the list and loads default registers.
// A finished result waits in the output register; the next transaction is taken meanwhile.

module flow_point_tracker_table_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // func, entry_index, flow_dx, flow_dy
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [71:0] m_axis_tdata,   // status, point_count, point_x, point_y, lookup_x, lookup_y
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [10:0] i_cfg_data
);

    localparam int CW = fptt_pkg::CNT_W;
    localparam int IW = fptt_pkg::IDX_W;

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {a[15], a} + {b[15], b};
        if (s[16] != s[15]) begin
            return s[16] ? 16'h8000 : 16'h7fff;
        end
        return s[15:0];
    endfunction

    function automatic logic [10:0] pix(input logic [15:0] q, input logic [10:0] size);
        logic [16:0] s;
        logic [12:0] r;
        s = {q[15], q} + 17'd8;
        r = s[16:4];
        if (q[15] || size == 11'd0) begin
            return 11'd0;
        end
        if (r > ({2'b00, size} - 13'd1)) begin
            return size - 11'd1;
        end
        return r[10:0];
    endfunction

    function automatic logic in_margin(input logic [15:0] q, input logic signed [16:0] hi);
        return ($signed({q[15], q}) >= 17'sd80) && ($signed({q[15], q}) <= hi);
    endfunction

    fptt_pkg::t_state   r_state, n_state;
    fptt_pkg::t_mem_req mem_req;

    logic [10:0]        r_width, r_height;
    logic [7:0]         r_gap;
    logic [15:0]        r_gap_sq;
    logic signed [16:0] r_xhi, r_yhi;

    logic [1:0]  r_func, n_func;
    logic [9:0]  r_idx, n_idx;
    logic [15:0] r_dx, n_dx, r_dy, n_dy;
    logic [CW-1:0] r_count, n_count, r_i, n_i, r_j, n_j, r_k, n_k;
    logic [15:0] r_pvx, n_pvx, r_pvy, n_pvy, r_cx, n_cx, r_cy, n_cy;
    logic [10:0] r_nx, n_nx, r_ny, n_ny, r_gx, n_gx, r_gy, n_gy;
    logic [15:0] r_q0x, n_q0x, r_q0y, n_q0y, r_qx, n_qx, r_qy, n_qy;
    logic [11:0] r_r0x, n_r0x, r_r0y, n_r0y, r_rx, n_rx, r_ry, n_ry;
    logic [11:0] r_dvx, n_dvx, r_dvy, n_dvy;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_px, n_px, r_py, n_py;
    logic [10:0] r_lx, n_lx, r_ly, n_ly;

    logic        r_o_valid;
    logic [71:0] r_o_data;
    logic        o_load;

    logic [15:0] mem_rx, mem_ry;
    logic        div_start, div_done;
    logic [15:0] div_dvd, div_quot;
    logic [11:0] div_dvs, div_rem;
    logic [15:0] near_ax, near_ay;
    logic        near;
    logic [15:0] grid_x, grid_y;
    logic [12:0] sum_rx, sum_ry;
    logic        do_append, do_advance, keep;
    logic [15:0] nx_pos, ny_pos;

    fptt_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rx  (mem_rx),
        .o_ry  (mem_ry)
    );

    fptt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    fptt_near u_near (
        .i_clk  (i_clk),
        .i_ax   (near_ax),
        .i_ay   (near_ay),
        .i_bx   (mem_rx),
        .i_by   (mem_ry),
        .i_lim  ({r_gap_sq, 8'h00}),
        .o_near (near)
    );

    assign grid_x  = {5'b0, r_gap, 3'b000} + r_qx;
    assign grid_y  = {5'b0, r_gap, 3'b000} + r_qy;
    assign near_ax = (r_state == fptt_pkg::ST_RS_SQ) ? grid_x : r_pvx;
    assign near_ay = (r_state == fptt_pkg::ST_RS_SQ) ? grid_y : r_pvy;
    assign sum_rx  = {1'b0, r_rx} + {1'b0, r_r0x};
    assign sum_ry  = {1'b0, r_ry} + {1'b0, r_r0y};

    always_comb begin
        n_state = r_state;
        n_func = r_func; n_idx = r_idx; n_dx = r_dx; n_dy = r_dy;
        n_count = r_count; n_i = r_i; n_j = r_j; n_k = r_k;
        n_pvx = r_pvx; n_pvy = r_pvy; n_cx = r_cx; n_cy = r_cy;
        n_nx = r_nx; n_ny = r_ny; n_gx = r_gx; n_gy = r_gy;
        n_q0x = r_q0x; n_q0y = r_q0y; n_qx = r_qx; n_qy = r_qy;
        n_r0x = r_r0x; n_r0y = r_r0y; n_rx = r_rx; n_ry = r_ry;
        n_dvx = r_dvx; n_dvy = r_dvy;
        n_status = r_status; n_px = r_px; n_py = r_py; n_lx = r_lx; n_ly = r_ly;
        mem_req       = '0;
        mem_req.raddr = r_i[IW-1:0];
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dvs    = '0;
        do_append  = 1'b0;
        do_advance = 1'b0;
        keep       = 1'b0;
        nx_pos     = mem_rx;
        ny_pos     = mem_ry;
        o_load     = 1'b0;
        s_axis_tready = (r_state == fptt_pkg::ST_IDLE);

        case (r_state)
            fptt_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func = s_axis_tdata[1:0];
                    n_idx  = s_axis_tdata[11:2];
                    n_dx   = s_axis_tdata[27:12];
                    n_dy   = s_axis_tdata[43:28];
                    n_status = fptt_pkg::STATUS_OK;
                    n_px = '0; n_py = '0; n_lx = '0; n_ly = '0;
                    n_i = '0; n_k = '0;
                    case (s_axis_tdata[1:0])
                        fptt_pkg::FUNC_PRUNE: begin
                            n_state = (r_count == '0) ? fptt_pkg::ST_PV_ISSUE
                                                      : fptt_pkg::ST_MG_ISSUE;
                        end
                        fptt_pkg::FUNC_RESEED: begin
                            if (r_gap == 8'd0) begin
                                n_status = fptt_pkg::STATUS_GAP;
                                n_state  = fptt_pkg::ST_DONE;
                            end else begin
                                div_start = 1'b1;
                                div_dvd   = {5'b0, r_width};
                                div_dvs   = {4'b0, r_gap};
                                n_state   = fptt_pkg::ST_RS_DIV_NX;
                            end
                        end
                        default: begin
                            if ({1'b0, s_axis_tdata[11:2]} >= r_count) begin
                                n_status = fptt_pkg::STATUS_INDEX;
                                n_state  = fptt_pkg::ST_DONE;
                            end else begin
                                mem_req.raddr = s_axis_tdata[11:2];
                                n_state = fptt_pkg::ST_RD_DATA;
                            end
                        end
                    endcase
                end
            end
            fptt_pkg::ST_RD_DATA: begin
                if (r_func == fptt_pkg::FUNC_DISPLACE) begin
                    nx_pos = sat_add(mem_rx, r_dx);
                    ny_pos = sat_add(mem_ry, r_dy);
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_idx;
                    mem_req.wx    = nx_pos;
                    mem_req.wy    = ny_pos;
                end
                n_px = nx_pos;
                n_py = ny_pos;
                n_state = fptt_pkg::ST_RD_CALC;
            end
            fptt_pkg::ST_RD_CALC: begin
                n_lx = pix(r_px, r_width);
                n_ly = pix(r_py, r_height);
                n_state = fptt_pkg::ST_DONE;
            end
            fptt_pkg::ST_MG_ISSUE: begin
                mem_req.raddr = r_i[IW-1:0];
                n_state = fptt_pkg::ST_MG_CHECK;
            end
            fptt_pkg::ST_MG_CHECK: begin
                keep = in_margin(mem_rx, r_xhi) && in_margin(mem_ry, r_yhi);
                mem_req.we    = keep;
                mem_req.waddr = r_k[IW-1:0];
                mem_req.wx    = mem_rx;
                mem_req.wy    = mem_ry;
                n_k = r_k + CW'(keep);
                n_i = r_i + CW'(1);
                if (r_i + CW'(1) == r_count) begin
                    n_count = r_k + CW'(keep);
                    n_i     = '0;
                    n_state = fptt_pkg::ST_PV_ISSUE;
                end else begin
                    n_state = fptt_pkg::ST_MG_ISSUE;
                end
            end
            fptt_pkg::ST_PV_ISSUE: begin
                mem_req.raddr = r_i[IW-1:0];
                n_state = (r_i >= r_count) ? fptt_pkg::ST_DONE : fptt_pkg::ST_PV_LOAD;
            end
            fptt_pkg::ST_PV_LOAD: begin
                n_pvx = mem_rx;
                n_pvy = mem_ry;
                n_j = r_i + CW'(1);
                n_k = r_i + CW'(1);
                if (r_i + CW'(1) >= r_count) begin
                    n_i = r_i + CW'(1);
                    n_state = fptt_pkg::ST_PV_ISSUE;
                end else begin
                    n_state = fptt_pkg::ST_PJ_ISSUE;
                end
            end
            fptt_pkg::ST_PJ_ISSUE: begin
                mem_req.raddr = r_j[IW-1:0];
                n_state = fptt_pkg::ST_PJ_SQ;
            end
            fptt_pkg::ST_PJ_SQ: begin
                n_cx = mem_rx;
                n_cy = mem_ry;
                n_state = fptt_pkg::ST_PJ_CMP;
            end
            fptt_pkg::ST_PJ_CMP: begin
                mem_req.we    = !near;
                mem_req.waddr = r_k[IW-1:0];
                mem_req.wx    = r_cx;
                mem_req.wy    = r_cy;
                n_k = r_k + CW'(!near);
                n_j = r_j + CW'(1);
                if (r_j + CW'(1) == r_count) begin
                    n_count = r_k + CW'(!near);
                    n_i     = r_i + CW'(1);
                    n_state = fptt_pkg::ST_PV_ISSUE;
                end else begin
                    n_state = fptt_pkg::ST_PJ_ISSUE;
                end
            end
            fptt_pkg::ST_RS_DIV_NX: begin
                if (div_done) begin
                    n_nx      = div_quot[10:0];
                    div_start = 1'b1;
                    div_dvd   = {5'b0, r_height};
                    div_dvs   = {4'b0, r_gap};
                    n_state   = fptt_pkg::ST_RS_DIV_NY;
                end
            end
            fptt_pkg::ST_RS_DIV_NY: begin
                if (div_done) begin
                    n_ny = div_quot[10:0];
                    if (r_nx == '0 || div_quot == '0) begin
                        n_status = fptt_pkg::STATUS_GAP;
                        n_state  = fptt_pkg::ST_DONE;
                    end else begin
                        div_start = 1'b1;
                        div_dvd   = {r_width - {3'b0, r_gap}, 5'b00000};
                        div_dvs   = {r_nx - 11'd1, 1'b0};
                        n_dvx     = {r_nx - 11'd1, 1'b0};
                        n_state   = fptt_pkg::ST_RS_DIV_SX;
                    end
                end
            end
            fptt_pkg::ST_RS_DIV_SX: begin
                if (div_done) begin
                    n_q0x     = div_quot;
                    n_r0x     = div_rem;
                    div_start = 1'b1;
                    div_dvd   = {r_height - {3'b0, r_gap}, 5'b00000};
                    div_dvs   = {r_ny - 11'd1, 1'b0};
                    n_dvy     = {r_ny - 11'd1, 1'b0};
                    n_state   = fptt_pkg::ST_RS_DIV_SY;
                end
            end
            fptt_pkg::ST_RS_DIV_SY: begin
                if (div_done) begin
                    n_q0y = div_quot;
                    n_r0y = div_rem;
                    n_gx = '0; n_gy = '0; n_qx = '0; n_qy = '0;
                    n_rx = {1'b0, r_nx - 11'd1};
                    n_ry = {1'b0, r_ny - 11'd1};
                    n_state = fptt_pkg::ST_RS_POINT;
                end
            end
            fptt_pkg::ST_RS_POINT: begin
                n_i = '0;
                if (r_count == '0) begin
                    do_append = 1'b1;
                end else begin
                    n_state = fptt_pkg::ST_RS_ISSUE;
                end
            end
            fptt_pkg::ST_RS_ISSUE: begin
                mem_req.raddr = r_i[IW-1:0];
                n_state = fptt_pkg::ST_RS_SQ;
            end
            fptt_pkg::ST_RS_SQ: begin
                n_state = fptt_pkg::ST_RS_CMP;
            end
            fptt_pkg::ST_RS_CMP: begin
                if (near) begin
                    do_advance = 1'b1;
                end else begin
                    n_i = r_i + CW'(1);
                    if (r_i + CW'(1) == r_count) begin
                        do_append = 1'b1;
                    end else begin
                        n_state = fptt_pkg::ST_RS_ISSUE;
                    end
                end
            end
            fptt_pkg::ST_DONE: begin
                if (!r_o_valid || m_axis_tready) begin
                    o_load  = 1'b1;
                    n_state = fptt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fptt_pkg::ST_IDLE;
            end
        endcase

        if (do_append) begin
            if (r_count >= CW'(fptt_pkg::MAX_POINTS)) begin
                n_status = fptt_pkg::STATUS_FULL;
                n_state  = fptt_pkg::ST_DONE;
            end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_count[IW-1:0];
                mem_req.wx    = grid_x;
                mem_req.wy    = grid_y;
                n_count    = r_count + CW'(1);
                do_advance = 1'b1;
            end
        end

        if (do_advance) begin
            n_state = fptt_pkg::ST_RS_POINT;
            if (r_gx + 11'd1 == r_nx) begin
                n_gx = '0;
                n_qx = '0;
                n_rx = {1'b0, r_nx - 11'd1};
                if (r_gy + 11'd1 == r_ny) begin
                    n_state = fptt_pkg::ST_DONE;
                end else begin
                    n_gy = r_gy + 11'd1;
                    if (sum_ry >= {1'b0, r_dvy}) begin
                        n_ry = 12'(sum_ry - {1'b0, r_dvy});
                        n_qy = r_qy + r_q0y + 16'd1;
                    end else begin
                        n_ry = sum_ry[11:0];
                        n_qy = r_qy + r_q0y;
                    end
                end
            end else begin
                n_gx = r_gx + 11'd1;
                if (sum_rx >= {1'b0, r_dvx}) begin
                    n_rx = 12'(sum_rx - {1'b0, r_dvx});
                    n_qx = r_qx + r_q0x + 16'd1;
                end else begin
                    n_rx = sum_rx[11:0];
                    n_qx = r_qx + r_q0x;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fptt_pkg::ST_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_width   <= 11'd640;
            r_height  <= 11'd480;
            r_gap     <= 8'd8;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (o_load) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fptt_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    fptt_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    fptt_pkg::CFG_GAP:    r_gap    <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gap_sq <= r_gap * r_gap;
        r_xhi <= $signed({2'b00, r_width, 4'b0000} - 17'd96);
        r_yhi <= $signed({2'b00, r_height, 4'b0000} - 17'd96);
        r_func <= n_func; r_idx <= n_idx; r_dx <= n_dx; r_dy <= n_dy;
        r_i <= n_i; r_j <= n_j; r_k <= n_k;
        r_pvx <= n_pvx; r_pvy <= n_pvy; r_cx <= n_cx; r_cy <= n_cy;
        r_nx <= n_nx; r_ny <= n_ny; r_gx <= n_gx; r_gy <= n_gy;
        r_q0x <= n_q0x; r_q0y <= n_q0y; r_qx <= n_qx; r_qy <= n_qy;
        r_r0x <= n_r0x; r_r0y <= n_r0y; r_rx <= n_rx; r_ry <= n_ry;
        r_dvx <= n_dvx; r_dvy <= n_dvy;
        r_status <= n_status; r_px <= n_px; r_py <= n_py; r_lx <= n_lx; r_ly <= n_ly;
        if (o_load) begin
            r_o_data <= {5'b0, r_ly, r_lx, r_py, r_px, r_count, r_status};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(fptt_pkg::MAX_POINTS))
        else $error("point count above capacity");

    a_write_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> ({1'b0, mem_req.waddr} <= r_count))
        else $error("memory write beyond the list end");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && r_status == fptt_pkg::STATUS_FULL)
        |-> (r_count == CW'(fptt_pkg::MAX_POINTS)))
        else $error("list full reported below capacity");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> (!r_o_valid || m_axis_tready))
        else $error("result overwritten before transfer");
`endif

endmodule

`default_nettype wire
